// ===== src/cbm_pkg.sv =====
// Shared types, codes and constants for the cartridge bank mapper.
package cbm_pkg;

  // Address translation geometry
  localparam int unsigned ROM_BANK_BYTES = 16384;
  localparam int unsigned RAM_BANK_BYTES = 8192;
  localparam int unsigned EXT_RAM_BASE   = 40960;
  localparam int unsigned ROM_OFS_W      = $clog2(ROM_BANK_BYTES);
  localparam int unsigned RAM_OFS_W      = $clog2(RAM_BANK_BYTES);

  // Field widths
  localparam int unsigned REQ_W      = 2;
  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned DATA_W     = 8;
  localparam int unsigned MAPPED_W   = 23;
  localparam int unsigned ROM_BANK_W = MAPPED_W - ROM_OFS_W;
  localparam int unsigned UPPER_W    = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;

  // Default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Request types
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ROM   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RAM   = 2'd2;

  // Mapper types
  localparam logic [1:0] MAP_NONE = 2'd0;
  localparam logic [1:0] MAP_MBC1 = 2'd1;
  localparam logic [1:0] MAP_MBC3 = 2'd2;
  localparam logic [1:0] MAP_MBC5 = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAPPER_TYPE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HAS_CLOCK      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROM_BANK_COUNT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_BANK_COUNT = 2'd3;

  // Bus address range boundaries
  localparam logic [ADDR_W-1:0] ADR_ROMLO  = 16'h2000;
  localparam logic [ADDR_W-1:0] ADR_BIT8   = 16'h3000;
  localparam logic [ADDR_W-1:0] ADR_UPPER  = 16'h4000;
  localparam logic [ADDR_W-1:0] ADR_MODE   = 16'h6000;

  // Register write values
  localparam logic [DATA_W-1:0] RAM_ENABLE_KEY = 8'h0A;
  localparam logic [DATA_W-1:0] CLOCK_SEL_BASE = 8'h08;
  localparam logic [DATA_W-1:0] MBC3_MAX_BANK  = 8'h03;
  localparam logic [DATA_W-1:0] LATCH_VALUE    = 8'h01;
  localparam logic [DATA_W-1:0] MBC1_LOW_MASK  = 8'h1F;
  localparam logic [DATA_W-1:0] MBC3_LOW_MASK  = 8'h7F;
  localparam logic [CFG_DATA_W-1:0] LARGE_ROM_BANKS = 10'd32;

  // Configuration register set
  typedef struct packed {
    logic [1:0] mapper_type;
    logic       has_clock;
    logic [9:0] rom_bank_count;
    logic [4:0] ram_bank_count;
  } cfg_t;

  // Classified operation
  typedef enum logic [3:0] {
    OP_NOP,
    OP_WR_ENABLE,
    OP_WR_ROMLO,
    OP_WR_BIT8,
    OP_WR_UPPER,
    OP_WR_MODE,
    OP_ROM_RAW,
    OP_ROM_LOW,
    OP_ROM_BANK,
    OP_RAM
  } op_t;

  // Item passed from front to back
  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } item_t;

endpackage

// ===== src/cbm_front.sv =====
// Front end: accepts bus transactions and classifies them into operations.
module cbm_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cbm_pkg::cfg_t             cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [cbm_pkg::REQ_W-1:0] in_req_type,
  input  logic [cbm_pkg::ADDR_W-1:0] in_addr,
  input  logic [cbm_pkg::DATA_W-1:0] in_wdata,
  output logic                      push_valid,
  input  logic                      push_ready,
  output cbm_pkg::item_t            push_item
);

  logic           valid_r, valid_nxt;
  cbm_pkg::item_t item_r, item_nxt;
  cbm_pkg::op_t   op;

  // Decode request type, mapper and address range
  always_comb begin
    op = cbm_pkg::OP_NOP;
    if (in_req_type == cbm_pkg::REQ_WRITE) begin
      priority if (cfg.mapper_type == cbm_pkg::MAP_NONE) begin
        op = cbm_pkg::OP_NOP;
      end else if (in_addr < cbm_pkg::ADR_ROMLO) begin
        op = cbm_pkg::OP_WR_ENABLE;
      end else if (in_addr < cbm_pkg::ADR_BIT8) begin
        op = cbm_pkg::OP_WR_ROMLO;
      end else if (in_addr < cbm_pkg::ADR_UPPER) begin
        op = (cfg.mapper_type == cbm_pkg::MAP_MBC5) ? cbm_pkg::OP_WR_BIT8
                                                    : cbm_pkg::OP_WR_ROMLO;
      end else if (in_addr < cbm_pkg::ADR_MODE) begin
        op = cbm_pkg::OP_WR_UPPER;
      end else begin
        op = (cfg.mapper_type == cbm_pkg::MAP_MBC5) ? cbm_pkg::OP_NOP
                                                    : cbm_pkg::OP_WR_MODE;
      end
    end else if (in_req_type == cbm_pkg::REQ_ROM) begin
      priority if (cfg.mapper_type == cbm_pkg::MAP_NONE) begin
        op = cbm_pkg::OP_ROM_RAW;
      end else if (in_addr < cbm_pkg::ADR_UPPER) begin
        op = cbm_pkg::OP_ROM_LOW;
      end else begin
        op = cbm_pkg::OP_ROM_BANK;
      end
    end else if (in_req_type == cbm_pkg::REQ_RAM) begin
      op = cbm_pkg::OP_RAM;
    end
  end

  // Stage register: refills when empty or whenever it drains into the queue
  assign in_ready   = !valid_r || push_ready;
  assign push_valid = valid_r;
  assign push_item  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (in_ready) begin
      valid_nxt = in_valid;
      item_nxt  = '{op: op, addr: in_addr, wdata: in_wdata};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

endmodule

// ===== src/cbm_queue.sv =====
// Short FIFO that decouples the front end from the back end.
module cbm_queue #(
  parameter int unsigned DEPTH = cbm_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  cbm_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output cbm_pkg::item_t pop_item
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cbm_pkg::item_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign push_ready = (count_r != FULL_CNT);
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== src/cbm_back.sv =====
// Back end: bank registers, address translation and the result register.
module cbm_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cbm_pkg::cfg_t                 cfg,
  input  logic                          pop_valid,
  output logic                          pop_ready,
  input  cbm_pkg::item_t                pop_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cbm_pkg::MAPPED_W-1:0]  out_mapped_addr,
  output logic                          out_access_invalid,
  output logic                          out_save_request
);

  localparam int unsigned ROM_OFS_W  = cbm_pkg::ROM_OFS_W;
  localparam int unsigned RAM_OFS_W  = cbm_pkg::RAM_OFS_W;
  localparam int unsigned ROM_BANK_W = cbm_pkg::ROM_BANK_W;
  localparam int unsigned MAPPED_W   = cbm_pkg::MAPPED_W;
  localparam int unsigned DATA_W     = cbm_pkg::DATA_W;
  localparam int unsigned UPPER_W    = cbm_pkg::UPPER_W;
  localparam int unsigned SUM_W      = DATA_W + 2;

  // Mapper state
  logic [DATA_W-1:0]  rom_low_r, rom_low_nxt;
  logic [UPPER_W-1:0] upper_r, upper_nxt;
  logic               mode_r, mode_nxt;
  logic               ram_en_r, ram_en_nxt;
  logic               latched_r, latched_nxt;
  logic [DATA_W-1:0]  clk_sel_r, clk_sel_nxt;

  // Result register
  logic                out_valid_r, out_valid_nxt;
  logic [MAPPED_W-1:0] mapped_r, mapped_nxt;
  logic                invalid_r, invalid_nxt;
  logic                save_r, save_nxt;

  logic                take, big_rom, clk_access, key_match;
  logic [DATA_W-1:0]   low_masked;
  logic [SUM_W-1:0]    bank_sum;
  logic [UPPER_W-1:0]  ram_bank;
  cbm_pkg::op_t        op;
  logic [cbm_pkg::ADDR_W-1:0] addr;
  logic [DATA_W-1:0]   wdata;

  assign op         = pop_item.op;
  assign addr       = pop_item.addr;
  assign wdata      = pop_item.wdata;
  assign take       = pop_valid && (!out_valid_r || out_ready);
  assign pop_ready  = !out_valid_r || out_ready;
  assign big_rom    = (cfg.rom_bank_count > cbm_pkg::LARGE_ROM_BANKS);
  assign clk_access = cfg.has_clock && ram_en_r;
  assign key_match  = (wdata == cbm_pkg::RAM_ENABLE_KEY);

  // Low bank write value, zero written as one
  always_comb begin
    low_masked = wdata & ((cfg.mapper_type == cbm_pkg::MAP_MBC1) ? cbm_pkg::MBC1_LOW_MASK
                                                                 : cbm_pkg::MBC3_LOW_MASK);
    if (low_masked == '0) begin
      low_masked = DATA_W'(1);
    end
  end

  // Switched ROM bank
  always_comb begin
    unique case (cfg.mapper_type)
      cbm_pkg::MAP_MBC1: bank_sum = SUM_W'(rom_low_r) +
                                    (big_rom ? SUM_W'({upper_r, 5'b0}) : '0);
      cbm_pkg::MAP_MBC5: bank_sum = SUM_W'({mode_r, rom_low_r});
      default:           bank_sum = SUM_W'(rom_low_r);
    endcase
  end

  // RAM bank
  always_comb begin
    unique case (cfg.mapper_type)
      cbm_pkg::MAP_NONE: ram_bank = '0;
      cbm_pkg::MAP_MBC1: ram_bank = mode_r ? upper_r : '0;
      default:           ram_bank = upper_r;
    endcase
  end

  // Execute one operation
  always_comb begin
    rom_low_nxt   = rom_low_r;
    upper_nxt     = upper_r;
    mode_nxt      = mode_r;
    ram_en_nxt    = ram_en_r;
    latched_nxt   = latched_r;
    clk_sel_nxt   = clk_sel_r;
    out_valid_nxt = out_valid_r;
    mapped_nxt    = mapped_r;
    invalid_nxt   = invalid_r;
    save_nxt      = save_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (take) begin
      out_valid_nxt = 1'b1;
      mapped_nxt    = '0;
      invalid_nxt   = 1'b0;
      save_nxt      = 1'b0;
      unique case (op)
        cbm_pkg::OP_NOP: begin
        end
        cbm_pkg::OP_WR_ENABLE: begin
          ram_en_nxt = key_match;
          save_nxt   = ram_en_r && !key_match;
        end
        cbm_pkg::OP_WR_ROMLO: begin
          rom_low_nxt = (cfg.mapper_type == cbm_pkg::MAP_MBC5) ? wdata : low_masked;
        end
        cbm_pkg::OP_WR_BIT8: begin
          mode_nxt = wdata[0];
        end
        cbm_pkg::OP_WR_UPPER: begin
          unique case (cfg.mapper_type)
            cbm_pkg::MAP_MBC1: upper_nxt = {2'b0, wdata[1:0]};
            cbm_pkg::MAP_MBC3: begin
              priority if (clk_access && wdata >= cbm_pkg::CLOCK_SEL_BASE) begin
                clk_sel_nxt = wdata - cbm_pkg::CLOCK_SEL_BASE;
              end else if (wdata <= cbm_pkg::MBC3_MAX_BANK) begin
                upper_nxt = wdata[UPPER_W-1:0];
              end
            end
            default: upper_nxt = wdata[UPPER_W-1:0];
          endcase
        end
        cbm_pkg::OP_WR_MODE: begin
          if (cfg.mapper_type == cbm_pkg::MAP_MBC1) begin
            mode_nxt = (wdata != '0);
          end else if (clk_access) begin
            latched_nxt = (wdata == cbm_pkg::LATCH_VALUE);
          end
        end
        cbm_pkg::OP_ROM_RAW: begin
          mapped_nxt = MAPPED_W'(addr);
        end
        cbm_pkg::OP_ROM_LOW: begin
          if (cfg.mapper_type == cbm_pkg::MAP_MBC1 && big_rom && mode_r) begin
            mapped_nxt = MAPPED_W'({upper_r, 5'b0, addr[ROM_OFS_W-1:0]});
          end else begin
            mapped_nxt = MAPPED_W'(addr);
          end
        end
        cbm_pkg::OP_ROM_BANK: begin
          mapped_nxt = {bank_sum[ROM_BANK_W-1:0], addr[ROM_OFS_W-1:0]};
        end
        cbm_pkg::OP_RAM: begin
          if (cfg.ram_bank_count == '0 || !ram_en_r) begin
            mapped_nxt  = MAPPED_W'(addr);
            invalid_nxt = 1'b1;
          end else begin
            // base address has zero low bits, so the offset is the low bits
            mapped_nxt = MAPPED_W'({ram_bank, addr[RAM_OFS_W-1:0]});
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_low_r   <= DATA_W'(1);
      upper_r     <= '0;
      mode_r      <= 1'b0;
      ram_en_r    <= 1'b0;
      latched_r   <= 1'b0;
      clk_sel_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rom_low_r   <= rom_low_nxt;
      upper_r     <= upper_nxt;
      mode_r      <= mode_nxt;
      ram_en_r    <= ram_en_nxt;
      latched_r   <= latched_nxt;
      clk_sel_r   <= clk_sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mapped_r  <= mapped_nxt;
    invalid_r <= invalid_nxt;
    save_r    <= save_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_mapped_addr    = mapped_r;
  assign out_access_invalid = invalid_r;
  assign out_save_request   = save_r;

endmodule

// ===== src/cartridge_bank_mapper.sv =====
// Top level of the cartridge bank mapper: configuration registers and the
// front end, queue and back end.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_ready    in_req_type, in_addr, in_wdata
//   out_     output     out_valid/out_ready  out_mapped_addr, out_access_invalid,
//                                            out_save_request
//   cfg_     input      cfg_we               cfg_index, cfg_wdata
//
// One transaction per cycle sustained while out_ready stays high; a request
// passes the front stage, the queue and then the result register.
// Synchronous active-low reset restores bank state and configuration defaults.
// A stalled output fills the queue first; the input stalls only once the
// queue and the front stage are both full.
module cartridge_bank_mapper #(
  parameter int unsigned QUEUE_DEPTH = cbm_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [cbm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cbm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [cbm_pkg::REQ_W-1:0]         in_req_type,
  input  logic [cbm_pkg::ADDR_W-1:0]        in_addr,
  input  logic [cbm_pkg::DATA_W-1:0]        in_wdata,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [cbm_pkg::MAPPED_W-1:0]      out_mapped_addr,
  output logic                              out_access_invalid,
  output logic                              out_save_request
);

  cbm_pkg::cfg_t  cfg_r, cfg_nxt;
  logic           push_valid, push_ready, pop_valid, pop_ready;
  cbm_pkg::item_t push_item, pop_item;

  // Configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        cbm_pkg::CFG_MAPPER_TYPE:    cfg_nxt.mapper_type    = cfg_wdata[1:0];
        cbm_pkg::CFG_HAS_CLOCK:      cfg_nxt.has_clock      = cfg_wdata[0];
        cbm_pkg::CFG_ROM_BANK_COUNT: cfg_nxt.rom_bank_count = cfg_wdata[9:0];
        cbm_pkg::CFG_RAM_BANK_COUNT: cfg_nxt.ram_bank_count = cfg_wdata[4:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{mapper_type: cbm_pkg::MAP_NONE, has_clock: 1'b0,
                 rom_bank_count: 10'd2, ram_bank_count: 5'd0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  cbm_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .in_addr     (in_addr),
    .in_wdata    (in_wdata),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_item   (push_item)
  );

  cbm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  cbm_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .pop_valid          (pop_valid),
    .pop_ready          (pop_ready),
    .pop_item           (pop_item),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_mapped_addr    (out_mapped_addr),
    .out_access_invalid (out_access_invalid),
    .out_save_request   (out_save_request)
  );

endmodule
